// ===== hw/rtl/mcr_pkg.sv =====
// Shared types, constants and lookup tables for the midpoint circle rasterizer.
// Used by every module under hw/rtl; depends on nothing else.
package mcr_pkg;

  localparam int COORD_BITS = 12;
  localparam int OUT_BITS   = COORD_BITS + 1;
  localparam int DEC_BITS   = COORD_BITS + 4;
  // Signed width that holds every centre plus or minus offset without overflow.
  localparam int SUM_BITS   = COORD_BITS + 3;
  localparam int CFG_BITS   = 13;
  localparam int CMP_BITS   = (SUM_BITS > CFG_BITS) ? SUM_BITS : CFG_BITS;

  localparam int NPTS   = 8;
  localparam int NSPANS = 4;
  localparam int SEL_BITS = 3;

  localparam int QUEUE_DEPTH = 2;

  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_HEIGHT = 1'b1;

  localparam logic [CFG_BITS-1:0] SCREEN_WIDTH_RST  = CFG_BITS'(240);
  localparam logic [CFG_BITS-1:0] SCREEN_HEIGHT_RST = CFG_BITS'(320);

  localparam logic [DEC_BITS-1:0] DEC_INIT   = DEC_BITS'(3);
  localparam logic [DEC_BITS-1:0] DEC_STEP_A = DEC_BITS'(6);
  localparam logic [DEC_BITS-1:0] DEC_STEP_B = DEC_BITS'(10);

  localparam logic [NPTS-1:0] FILL_EMIT = NPTS'(8'h0F);

  // Candidate coordinates: 0 cx-x, 1 cy-y, 2 cx-y, 3 cy-x,
  //                        4 cx+x, 5 cy+y, 6 cx+y, 7 cy+x.
  localparam logic [NPTS-1:0] PIX_SKIP [NPTS] = '{
    8'h03, 8'h12, 8'h21, 8'h30, 8'h0C, 8'h48, 8'h84, 8'hC0
  };
  localparam logic [SEL_BITS-1:0] PIX_X [NPTS] = '{
    3'd0, 3'd4, 3'd0, 3'd4, 3'd2, 3'd6, 3'd2, 3'd6
  };
  localparam logic [SEL_BITS-1:0] PIX_Y [NPTS] = '{
    3'd1, 3'd1, 3'd5, 3'd5, 3'd3, 3'd3, 3'd7, 3'd7
  };

  localparam logic [SEL_BITS-1:0] FILL_ROW [NSPANS] = '{3'd1, 3'd5, 3'd7, 3'd3};
  localparam logic [SEL_BITS-1:0] FILL_X   [NSPANS] = '{3'd0, 3'd0, 3'd2, 3'd2};
  localparam logic [SEL_BITS-1:0] FILL_END [NSPANS] = '{3'd4, 3'd4, 3'd6, 3'd6};

  typedef struct packed {
    logic                  mode;
    logic [COORD_BITS-1:0] center_x;
    logic [COORD_BITS-1:0] center_y;
    logic [COORD_BITS-1:0] radius;
    logic                  fill;
  } in_item_t;

  typedef struct packed {
    logic                draw;
    logic [OUT_BITS-1:0] row_y;
    logic [OUT_BITS-1:0] start_x;
    logic [OUT_BITS-1:0] span_length;
    logic                is_span;
    logic                last_of_run;
    logic                finished;
  } out_item_t;

  // One classified iteration, handed from the front end to the back end.
  typedef struct packed {
    logic                           fill;
    logic                           fin;
    logic [NPTS-1:0]                emit;
    logic [NPTS-1:0][OUT_BITS-1:0]  coord;
  } job_t;

endpackage

// ===== hw/rtl/midpoint_circle_rasterizer.sv =====
// Top level of the midpoint circle rasterizer: screen registers, front end,
// job queue and back end. Uses mcr_pkg, mcr_front, mcr_queue and mcr_back.
//
//   channel  ports                            transfer when
//   input    in_item, in_push, in_full        in_push && !in_full
//   result   out_item, out_empty, out_pop     out_pop && !out_empty
//   config   cfg_we, cfg_index, cfg_wdata     cfg_we
//
// An item is taken in the cycle it arrives while the job queue has room; the
// back end gives one result per cycle unless the result stage is stalled: one
// result for an idle step or no pixel drawn, four (fill), up to eight (outline).
// Reset (rst_n low at a clock edge) clears all control state and loads the
// screen registers with 240 by 320. A stalled result stage holds its result
// while the front end keeps filling the queue.
module midpoint_circle_rasterizer #(
  parameter int QUEUE_DEPTH = mcr_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mcr_pkg::in_item_t                 in_item,
  input  logic                              in_push,
  output logic                              in_full,
  output mcr_pkg::out_item_t                out_item,
  output logic                              out_empty,
  input  logic                              out_pop,
  input  logic                              cfg_we,
  input  logic [mcr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [mcr_pkg::CFG_BITS-1:0]      cfg_wdata
);
  import mcr_pkg::*;

  logic [CFG_BITS-1:0] screen_width_r, screen_height_r;
  logic                accept, job_valid, job_pop;
  job_t                front_job, head_job;

  assign accept = in_push & ~in_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r  <= SCREEN_WIDTH_RST;
      screen_height_r <= SCREEN_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCREEN_WIDTH:  screen_width_r  <= cfg_wdata;
        CFG_SCREEN_HEIGHT: screen_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  mcr_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_item       (in_item),
    .accept        (accept),
    .screen_width  (screen_width_r),
    .screen_height (screen_height_r),
    .job           (front_job)
  );

  mcr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (accept),
    .din   (front_job),
    .full  (in_full),
    .pop   (job_pop),
    .dout  (head_job),
    .valid (job_valid)
  );

  mcr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (head_job),
    .job_valid (job_valid),
    .job_pop   (job_pop),
    .out_item  (out_item),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

endmodule

// ===== hw/rtl/mcr_front.sv =====
// Front end: holds the circle state, runs one midpoint iteration per accepted
// item and turns it into a job (coordinates, emit mask, finished flag). Uses mcr_pkg.
module mcr_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mcr_pkg::in_item_t             in_item,
  input  logic                          accept,
  input  logic [mcr_pkg::CFG_BITS-1:0]  screen_width,
  input  logic [mcr_pkg::CFG_BITS-1:0]  screen_height,
  output mcr_pkg::job_t                 job
);
  import mcr_pkg::*;

  logic [COORD_BITS-1:0] cx_r, cy_r, cx_nxt, cy_nxt;
  logic                  fill_r, fill_nxt;
  logic [OUT_BITS-1:0]   x_r, y_r, x_nxt, y_nxt;
  logic [DEC_BITS-1:0]   d_r, d_nxt;
  logic                  active_r, active_nxt;

  logic [COORD_BITS-1:0] cx, cy;
  logic                  fill;
  logic [OUT_BITS-1:0]   x, y;
  logic [DEC_BITS-1:0]   d, d_diff;
  logic                  act, d_neg, fin;
  logic [OUT_BITS:0]     x_ahead;
  logic [SUM_BITS-1:0]   q [NPTS];
  logic [NPTS-1:0]       skip, pix_emit;
  logic [NPTS-1:0][OUT_BITS-1:0] coord;

  // Operands: a start item supplies fresh values, a step item uses the state.
  always_comb begin
    if (in_item.mode) begin
      cx   = in_item.center_x;
      cy   = in_item.center_y;
      fill = in_item.fill;
      x    = '0;
      y    = OUT_BITS'(in_item.radius);
      d    = DEC_INIT - {{(DEC_BITS-COORD_BITS-1){1'b0}}, in_item.radius, 1'b0};
    end else begin
      cx   = cx_r;
      cy   = cy_r;
      fill = fill_r;
      x    = x_r;
      y    = y_r;
      d    = d_r;
    end
    act = in_item.mode | active_r;
  end

  always_comb begin
    q[0] = SUM_BITS'(cx) - SUM_BITS'(x);
    q[1] = SUM_BITS'(cy) - SUM_BITS'(y);
    q[2] = SUM_BITS'(cx) - SUM_BITS'(y);
    q[3] = SUM_BITS'(cy) - SUM_BITS'(x);
    q[4] = SUM_BITS'(cx) + SUM_BITS'(x);
    q[5] = SUM_BITS'(cy) + SUM_BITS'(y);
    q[6] = SUM_BITS'(cx) + SUM_BITS'(y);
    q[7] = SUM_BITS'(cy) + SUM_BITS'(x);

    skip[0] = q[0][SUM_BITS-1];
    skip[1] = q[1][SUM_BITS-1];
    skip[2] = q[2][SUM_BITS-1];
    skip[3] = q[3][SUM_BITS-1];
    skip[4] = CMP_BITS'(q[4]) >= CMP_BITS'(screen_width);
    skip[5] = CMP_BITS'(q[5]) >= CMP_BITS'(screen_height);
    skip[6] = CMP_BITS'(q[6]) >= CMP_BITS'(screen_width);
    skip[7] = CMP_BITS'(q[7]) >= CMP_BITS'(screen_height);

    for (int k = 0; k < NPTS; k++) begin
      pix_emit[k] = (skip & PIX_SKIP[k]) == '0;
    end

    // The low coordinates clamp at zero; an outline pixel that uses a
    // negative one is skipped anyway, so the clamp is harmless there.
    for (int k = 0; k < NPTS; k++) begin
      if (k < NSPANS && q[k][SUM_BITS-1]) begin
        coord[k] = '0;
      end else begin
        coord[k] = q[k][OUT_BITS-1:0];
      end
    end
  end

  // Decision term and offset update.
  always_comb begin
    d_neg   = d[DEC_BITS-1];
    d_diff  = DEC_BITS'(x) - DEC_BITS'(y);
    x_ahead = {1'b0, x} + (d_neg ? (OUT_BITS+1)'(1) : (OUT_BITS+1)'(2));
    fin     = x_ahead > {1'b0, y};
    if (d_neg) begin
      d_nxt = d + DEC_BITS'({x, 2'b00}) + DEC_STEP_A;
      y_nxt = y;
    end else begin
      d_nxt = d + {d_diff[DEC_BITS-3:0], 2'b00} + DEC_STEP_B;
      y_nxt = y - OUT_BITS'(1);
    end
    x_nxt      = x + OUT_BITS'(1);
    cx_nxt     = cx;
    cy_nxt     = cy;
    fill_nxt   = fill;
    active_nxt = ~fin;

    job.coord = coord;
    job.fill  = act & fill;
    job.fin   = act ? fin : 1'b1;
    if (!act) begin
      job.emit = '0;
    end else if (fill) begin
      job.emit = FILL_EMIT;
    end else begin
      job.emit = pix_emit;
    end
  end

  // A step item with no circle in progress leaves the state as it is.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r     <= '0;
      cy_r     <= '0;
      fill_r   <= 1'b0;
      x_r      <= '0;
      y_r      <= '0;
      d_r      <= '0;
      active_r <= 1'b0;
    end else if (accept && act) begin
      cx_r     <= cx_nxt;
      cy_r     <= cy_nxt;
      fill_r   <= fill_nxt;
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      d_r      <= d_nxt;
      active_r <= active_nxt;
    end
  end

endmodule

// ===== hw/rtl/mcr_queue.sv =====
// Small job queue between the front and back ends, in flip-flops.
// Uses mcr_pkg for the job type.
module mcr_queue #(
  parameter int DEPTH = mcr_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mcr_pkg::job_t  din,
  output logic           full,
  input  logic           pop,
  output mcr_pkg::job_t  dout,
  output logic           valid
);
  import mcr_pkg::*;

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
  localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

  job_t                mem_r [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic                do_push, do_pop;

  assign full    = count_r == FULL_CNT;
  assign valid   = count_r != '0;
  assign dout    = mem_r[rd_ptr_r];
  assign do_push = push & ~full;
  assign do_pop  = pop & valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_BITS'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_BITS'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_BITS'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== hw/rtl/mcr_back.sv =====
// Back end: walks the emit mask of the head job into a registered result stage,
// one pixel or span per cycle while that stage is free or being read. Uses mcr_pkg.
module mcr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  mcr_pkg::job_t       job,
  input  logic                job_valid,
  output logic                job_pop,
  output mcr_pkg::out_item_t  out_item,
  output logic                out_empty,
  input  logic                out_pop
);
  import mcr_pkg::*;

  out_item_t             res_r, res_nxt;
  logic                  res_valid_r;
  logic                  started_r;
  logic [NPTS-1:0]       rem_r;
  logic [NPTS-1:0]       mask, low_bit, mask_left;
  logic [SEL_BITS-1:0]   sel;
  logic [1:0]            span_sel;
  logic                  adv, last;
  logic [OUT_BITS-1:0]   left_x, right_x;

  assign out_item  = res_r;
  assign out_empty = ~res_valid_r;
  assign adv       = job_valid & (~res_valid_r | out_pop);
  assign job_pop   = adv & last;

  always_comb begin
    mask      = started_r ? rem_r : job.emit;
    low_bit   = mask & (~mask + NPTS'(1));
    mask_left = mask & ~low_bit;
    last      = mask_left == '0;
    sel       = '0;
    for (int i = NPTS - 1; i >= 0; i--) begin
      if (mask[i]) begin
        sel = SEL_BITS'(i);
      end
    end
    span_sel = sel[1:0];
    left_x   = job.coord[FILL_X[span_sel]];
    right_x  = job.coord[FILL_END[span_sel]];

    res_nxt             = '0;
    res_nxt.last_of_run = last;
    res_nxt.finished    = job.fin;
    // An empty mask is a non-drawing result: idle step or all pixels clipped.
    if (mask != '0) begin
      res_nxt.draw = 1'b1;
      if (job.fill) begin
        res_nxt.row_y       = job.coord[FILL_ROW[span_sel]];
        res_nxt.start_x     = left_x;
        res_nxt.span_length = right_x - left_x;
        res_nxt.is_span     = 1'b1;
      end else begin
        res_nxt.row_y   = job.coord[PIX_Y[sel]];
        res_nxt.start_x = job.coord[PIX_X[sel]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
      started_r   <= 1'b0;
      rem_r       <= '0;
    end else if (adv) begin
      res_valid_r <= 1'b1;
      started_r   <= ~last;
      rem_r       <= mask_left;
    end else if (out_pop) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ===== sim/midpoint_circle_rasterizer_tb.sv =====
// Self-checking testbench for the midpoint circle rasterizer: directed and random
// circles, steps and screen settings, checked against an in-bench predictor.
// Depends on mcr_pkg and midpoint_circle_rasterizer from hw/rtl.
module midpoint_circle_rasterizer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mcr_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 3000;
  localparam int SETTLE       = 16;
  localparam int PHASE_ITEMS  = 82;
  localparam int MAX_REPORTS  = 40;

  // Candidate order: 0 cx-x, 1 cy-y, 2 cx-y, 3 cy-x, 4 cx+x, 5 cy+y, 6 cx+y, 7 cy+x.
  localparam int SPAN_ROW [4] = '{1, 5, 7, 3};
  localparam int SPAN_LEFT[4] = '{0, 0, 2, 2};
  localparam int SPAN_RIGHT[4] = '{4, 4, 6, 6};
  localparam logic [7:0] PT_MASK[8] = '{8'h03, 8'h12, 8'h21, 8'h30,
                                        8'h0C, 8'h48, 8'h84, 8'hC0};
  localparam int PT_XSEL[8] = '{0, 4, 0, 4, 2, 6, 2, 6};
  localparam int PT_YSEL[8] = '{1, 1, 5, 5, 3, 3, 7, 7};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  in_item_t in_item = '0;
  logic in_push = 1'b0;
  logic in_full;
  out_item_t out_item;
  logic out_empty;
  logic out_pop = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_BITS-1:0] cfg_wdata = '0;

  midpoint_circle_rasterizer dut (
    .clk(clk), .rst_n(rst_n),
    .in_item(in_item), .in_push(in_push), .in_full(in_full),
    .out_item(out_item), .out_empty(out_empty), .out_pop(out_pop),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Predictor copy of the screen and the circle state.
  logic [12:0] scr_w = 13'd240;
  logic [12:0] scr_h = 13'd320;
  logic [11:0] ctr_x = '0;
  logic [11:0] ctr_y = '0;
  logic        fill_on = 1'b0;
  logic [12:0] off_x = '0;
  logic [12:0] off_y = '0;
  logic [15:0] dterm = '0;
  logic        busy = 1'b0;

  in_item_t  pending_items[$];
  out_item_t expected_pixels[$];

  int queued_cnt = 0;
  int items_taken = 0;
  int results_checked = 0;
  int mismatches = 0;
  int settings_used = 1;
  int idle_pct = 14;
  logic in_took = 1'b0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int hold_cnt = 0;
  int quiet = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // One iteration of the rasterizer for an accepted item.
  function automatic void rasterize_step(in_item_t it);
    int cx, cy, x, y, d;
    int q[8];
    logic [7:0] skip;
    logic fin;
    out_item_t r;
    out_item_t batch[$];
    if (it.mode) begin
      ctr_x = it.center_x;
      ctr_y = it.center_y;
      fill_on = it.fill;
      off_x = '0;
      off_y = {1'b0, it.radius};
      dterm = 16'(3 - 2 * int'(it.radius));
      busy = 1'b1;
    end
    if (!busy) begin
      r = '0;
      r.last_of_run = 1'b1;
      r.finished = 1'b1;
      expected_pixels.push_back(r);
      return;
    end
    cx = int'(ctr_x);
    cy = int'(ctr_y);
    x = int'(off_x);
    y = int'(off_y);
    d = int'($signed(dterm));
    q[0] = cx - x; q[1] = cy - y; q[2] = cx - y; q[3] = cy - x;
    q[4] = cx + x; q[5] = cy + y; q[6] = cx + y; q[7] = cy + x;
    if (fill_on) begin
      for (int k = 0; k < 4; k++) if (q[k] < 0) q[k] = 0;
      for (int k = 0; k < 4; k++) begin
        r = '0;
        r.draw = 1'b1;
        r.is_span = 1'b1;
        r.row_y = 13'(q[SPAN_ROW[k]]);
        r.start_x = 13'(q[SPAN_LEFT[k]]);
        r.span_length = 13'(q[SPAN_RIGHT[k]] - q[SPAN_LEFT[k]]);
        batch.push_back(r);
      end
    end else begin
      skip = '0;
      for (int k = 0; k < 4; k++) if (q[k] < 0) skip[k] = 1'b1;
      if (q[4] >= int'(scr_w)) skip[4] = 1'b1;
      if (q[5] >= int'(scr_h)) skip[5] = 1'b1;
      if (q[6] >= int'(scr_w)) skip[6] = 1'b1;
      if (q[7] >= int'(scr_h)) skip[7] = 1'b1;
      for (int k = 0; k < 8; k++) begin
        if ((skip & PT_MASK[k]) == 8'h00) begin
          r = '0;
          r.draw = 1'b1;
          r.row_y = 13'(q[PT_YSEL[k]]);
          r.start_x = 13'(q[PT_XSEL[k]]);
          batch.push_back(r);
        end
      end
      // An outline iteration with every pixel off screen still answers once.
      if (batch.size() == 0) batch.push_back(out_item_t'('0));
    end
    if (d < 0) begin
      d += 4 * x + 6;
    end else begin
      d += 4 * (x - y) + 10;
      y--;
    end
    x++;
    fin = (x > y);
    off_x = 13'(x);
    off_y = 13'(y);
    dterm = 16'(d);
    busy = !fin;
    foreach (batch[k]) begin
      batch[k].finished = fin;
      batch[k].last_of_run = (k == batch.size() - 1);
      expected_pixels.push_back(batch[k]);
    end
  endfunction

  function automatic int circle_iters(int r);
    int x = 0;
    int y = r;
    int d = 3 - 2 * r;
    int n = 0;
    do begin
      n++;
      if (d < 0) begin
        d += 4 * x + 6;
      end else begin
        d += 4 * (x - y) + 10;
        y--;
      end
      x++;
    end while (x <= y);
    return n;
  endfunction

  function automatic int pick_coord(logic [12:0] bound);
    if (bound == 0 || $urandom_range(9) == 0) return $urandom_range(4095);
    return $urandom_range(((bound > 13'd4096) ? 4096 : int'(bound)) - 1);
  endfunction

  task automatic queue_item(logic mode, int cx, int cy, int r, logic fl);
    in_item_t it;
    it.mode = mode;
    it.center_x = 12'(cx);
    it.center_y = 12'(cy);
    it.radius = 12'(r);
    it.fill = fl;
    pending_items.push_back(it);
    queued_cnt++;
  endtask

  // Step fields other than mode are ignored by the block, so they carry noise.
  task automatic queue_step();
    queue_item(1'b0, $urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
               1'($urandom_range(1)));
  endtask

  task automatic queue_circle(int cx, int cy, int r, logic fl, int steps);
    queue_item(1'b1, cx, cy, r, fl);
    repeat (steps) queue_step();
  endtask

  task automatic queue_random(int n);
    int pick, r, iters, steps, first;
    first = queued_cnt;
    while (queued_cnt - first < n) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        r = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12);
        iters = circle_iters(r);
        steps = ($urandom_range(4) == 0) ? $urandom_range(iters - 1) : iters - 1;
        queue_circle(pick_coord(scr_w), pick_coord(scr_h), r, 1'($urandom_range(1)),
                     steps);
      end else if (pick < 85) begin
        queue_step();
      end else if (pick < 95) begin
        queue_circle($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                     1'($urandom_range(1)), $urandom_range(4));
      end else begin
        queue_circle($urandom_range(4095), $urandom_range(4095),
                     $urandom_range(1) ? 4095 : 0, 1'($urandom_range(1)),
                     $urandom_range(2));
      end
    end
  endtask

  task automatic set_screen(logic [12:0] w, logic [12:0] h);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_SCREEN_WIDTH;
    cfg_wdata <= w;
    @(negedge clk);
    cfg_index <= CFG_SCREEN_HEIGHT;
    cfg_wdata <= h;
    @(negedge clk);
    cfg_we <= 1'b0;
    scr_w = w;
    scr_h = h;
    settings_used++;
  endtask

  // Returns once every queued item is in and every predicted result is out.
  task automatic drain();
    @(negedge clk);
    while (items_taken != queued_cnt || expected_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic check_field(string name, logic [12:0] want, logic [12:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Input driver: holds an offered item until its transfer, then maybe idles.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else if (!in_push || in_took) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_item <= pending_items.pop_front();
        in_push <= 1'b1;
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // Result side: random idling, plus one long hold-off that fills the block.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (hold_req && !hold_done) begin
      out_pop <= 1'b0;
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt == HOLD_CYCLES - 1) hold_done <= 1'b1;
    end else begin
      out_pop <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t ns: result with nothing expected, expected none, got %p",
                     $time, out_item);
        end else begin
          want = expected_pixels.pop_front();
          results_checked++;
          check_field("draw", 13'(want.draw), 13'(out_item.draw));
          check_field("row_y", want.row_y, out_item.row_y);
          check_field("start_x", want.start_x, out_item.start_x);
          check_field("span_length", want.span_length, out_item.span_length);
          check_field("is_span", 13'(want.is_span), 13'(out_item.is_span));
          check_field("last_of_run", 13'(want.last_of_run), 13'(out_item.last_of_run));
          check_field("finished", 13'(want.finished), 13'(out_item.finished));
        end
      end
      if (in_push && !in_full) begin
        rasterize_step(in_item);
        items_taken++;
      end
    end
    in_took <= in_push && !in_full;
  end

  // Watchdog: too many cycles without any transfer means the block is stuck.
  initial begin
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_push && !in_full) || (out_pop && !out_empty) || cfg_we || !rst_n)
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t ns: no transfer for %0d cycles", $time, QUIET_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [12:0] w, h;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset screen size.
    queue_step();
    queue_circle(100, 100, 0, 1'b0, 0);
    queue_step();
    queue_circle(0, 0, 0, 1'b1, 0);
    queue_circle(0, 0, 3, 1'b0, circle_iters(3) - 1);
    queue_circle(2, 1, 5, 1'b1, circle_iters(5) - 1);
    queue_circle(239, 319, 2, 1'b0, circle_iters(2) - 1);
    queue_circle(4095, 4095, 4095, 1'b0, 2);
    queue_circle(4095, 4095, 4095, 1'b1, 1);
    queue_circle(0, 0, 4095, 1'b0, 1);
    queue_circle(120, 160, 7, 1'b0, 1);
    queue_item(1'b0, 4095, 4095, 4095, 1'b1);
    drain();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin
          w = 13'd4096;
          h = 13'd4096;
        end
        1: begin
          w = 13'd1;
          h = 13'd1;
        end
        2: begin
          w = 13'd0;
          h = 13'd8191;
        end
        3: begin
          w = 13'd8191;
          h = 13'd0;
        end
        default: begin
          w = 13'($urandom_range(4096, 1));
          h = 13'($urandom_range(4096, 1));
        end
      endcase
      set_screen(w, h);
      idle_pct = (p == 0) ? 0 : 14;
      if (p == 1) hold_req = 1'b1;
      queue_random(PHASE_ITEMS);
      drain();
    end

    $display("Checked %0d results from %0d items over %0d screen settings,",
             results_checked, items_taken, settings_used);
    $display("with fill and outline circles and a %0d-cycle result stall.", HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
